>>> design/sdo_pkg.sv
// Package: shared types, constants and codes for the expedited SDO server.
package sdo_pkg;

  // Object dictionary size and slot index width
  localparam int DICT_ENTRIES = 16;
  localparam int DICT_IDX_W   = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int SLOT_CMP_W   = 9;

  // Field widths
  localparam int NODE_ID_W = 7;
  localparam int CMD_W     = 8;
  localparam int INDEX_W   = 16;
  localparam int SUBIDX_W  = 8;
  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int SIZE_W    = 3;
  localparam int TX_ID_W   = 11;

  // Response identifier base
  localparam logic [TX_ID_W-1:0] TX_ID_BASE = 11'h580;

  // Request command bytes
  localparam logic [CMD_W-1:0] CMD_UPLOAD  = 8'h40;
  localparam logic [CMD_W-1:0] CMD_DNLD_1B = 8'h2F;
  localparam logic [CMD_W-1:0] CMD_DNLD_2B = 8'h2B;
  localparam logic [CMD_W-1:0] CMD_DNLD_4B = 8'h23;

  // Response command bytes
  localparam logic [CMD_W-1:0] RSP_UPLOAD_1B = 8'h4F;
  localparam logic [CMD_W-1:0] RSP_UPLOAD_2B = 8'h4B;
  localparam logic [CMD_W-1:0] RSP_UPLOAD_4B = 8'h43;
  localparam logic [CMD_W-1:0] RSP_DNLD_OK   = 8'h60;

  // Entry byte sizes
  localparam logic [SIZE_W-1:0] SIZE_1B = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_2B = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_4B = 3'd4;

  // Item function
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_LOAD    = 1'b1;

  typedef enum logic [1:0] {
    EMCY_NO_ENTRY  = 2'd0,
    EMCY_BAD_SIZE  = 2'd1,
    EMCY_BAD_CMD   = 2'd2,
    EMCY_SIZE_MISM = 2'd3
  } emcy_code_t;

  typedef struct packed {
    logic                func;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  obj_index;
    logic [SUBIDX_W-1:0] obj_subindex;
    logic [DATA_W-1:0]   payload;
    logic [SLOT_W-1:0]   slot;
    logic [SIZE_W-1:0]   entry_size;
  } req_t;

  typedef struct packed {
    logic                tx_valid;
    logic [TX_ID_W-1:0]  tx_id;
    logic [CMD_W-1:0]    tx_cmd;
    logic [INDEX_W-1:0]  tx_index;
    logic [SUBIDX_W-1:0] tx_subindex;
    logic [DATA_W-1:0]   tx_data;
    logic                emcy_valid;
    emcy_code_t          emcy_code;
  } rsp_t;

endpackage

>>> design/sdo_if.sv
// Interfaces: request and response channels of the expedited SDO server.
interface sdo_req_if;
  import sdo_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [CMD_W-1:0]    cmd;
  logic [INDEX_W-1:0]  obj_index;
  logic [SUBIDX_W-1:0] obj_subindex;
  logic [DATA_W-1:0]   payload;
  logic [SLOT_W-1:0]   slot;
  logic [SIZE_W-1:0]   entry_size;

  modport source (
    output valid, func, cmd, obj_index, obj_subindex, payload, slot, entry_size,
    input  ready
  );
  modport sink (
    input  valid, func, cmd, obj_index, obj_subindex, payload, slot, entry_size,
    output ready
  );
endinterface

interface sdo_rsp_if;
  import sdo_pkg::*;

  logic                valid;
  logic                ready;
  logic                tx_valid;
  logic [TX_ID_W-1:0]  tx_id;
  logic [CMD_W-1:0]    tx_cmd;
  logic [INDEX_W-1:0]  tx_index;
  logic [SUBIDX_W-1:0] tx_subindex;
  logic [DATA_W-1:0]   tx_data;
  logic                emcy_valid;
  logic [1:0]          emcy_code;

  modport source (
    output valid, tx_valid, tx_id, tx_cmd, tx_index, tx_subindex, tx_data,
           emcy_valid, emcy_code,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_id, tx_cmd, tx_index, tx_subindex, tx_data,
           emcy_valid, emcy_code,
    output ready
  );
endinterface

>>> design/sdo_expedited_server_core.sv
// Top level: expedited SDO server over a loadable object dictionary table.
//
// Channels: in_req carries one item per transaction, either a dictionary
// load (func=1: key, size and initial value into a slot) or an SDO request
// (func=0: command byte, index, subindex, 32-bit payload). out_rsp carries
// exactly one result per item: a response frame, an emergency report, or an
// all-zero result for a load. cfg_we/cfg_wdata set the node number used in
// the response identifier; write it only while the block is idle.
// Pipeline: one input register, then one result register that drives out_rsp.
// Throughput: one item per cycle while out_rsp does not stall; the
// dictionary lookup is a parallel key compare over all slots and
// the table update lands at the edge the result is registered, so the
// next item always sees it.
// Reset: node number returns to 1, all slots become invalid, both stages
// empty. When out_rsp stalls, the result register holds, the input register
// fills, and in_req.ready drops until the result is taken.
module sdo_expedited_server_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sdo_pkg::NODE_ID_W-1:0] cfg_wdata,
  sdo_req_if.sink                      in_req,
  sdo_rsp_if.source                    out_rsp
);
  import sdo_pkg::*;

  // Configuration
  logic [NODE_ID_W-1:0] node_id_r;

  // Dictionary table
  logic                entry_valid_r    [DICT_ENTRIES];
  logic [INDEX_W-1:0]  entry_index_r    [DICT_ENTRIES];
  logic [SUBIDX_W-1:0] entry_subindex_r [DICT_ENTRIES];
  logic [SIZE_W-1:0]   entry_bytes_r    [DICT_ENTRIES];
  logic [DATA_W-1:0]   entry_value_r    [DICT_ENTRIES];

  // Pipeline registers
  logic s0_valid_r;
  req_t s0_r;
  logic out_valid_r;
  rsp_t out_r;

  logic in_fire;
  logic advance;
  logic move;

  // Lookup and response
  logic                  hit_found;
  logic [DICT_IDX_W-1:0] hit_idx;
  logic [SIZE_W-1:0]     hit_bytes;
  logic [DATA_W-1:0]     hit_value;
  logic [SIZE_W-1:0]     wr_expect;
  logic [DATA_W-1:0]     wr_mask;
  logic [DATA_W-1:0]     rd_mask;
  logic                  load_we;
  logic                  store_we;
  rsp_t                  rsp_nxt;

  // Handshake
  assign advance      = !out_valid_r || out_rsp.ready;
  assign move         = s0_valid_r && advance;
  assign in_req.ready = !s0_valid_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;

  // Node number register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= NODE_ID_W'(1);
    end else if (cfg_we) begin
      node_id_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s0_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_r.func         <= in_req.func;
      s0_r.cmd          <= in_req.cmd;
      s0_r.obj_index    <= in_req.obj_index;
      s0_r.obj_subindex <= in_req.obj_subindex;
      s0_r.payload      <= in_req.payload;
      s0_r.slot         <= in_req.slot;
      s0_r.entry_size   <= in_req.entry_size;
    end
  end

  // Find the lowest valid slot whose key matches
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = DICT_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid_r[i] && entry_index_r[i] == s0_r.obj_index &&
          entry_subindex_r[i] == s0_r.obj_subindex) begin
        hit_found = 1'b1;
        hit_idx   = DICT_IDX_W'(i);
      end
    end
  end

  assign hit_bytes = entry_bytes_r[hit_idx];
  assign hit_value = entry_value_r[hit_idx];

  // Build the result and decide on table updates
  always_comb begin
    rsp_nxt   = '0;
    wr_expect = '0;
    wr_mask   = '1;
    rd_mask   = '1;
    store_we  = 1'b0;
    load_we   = 1'b0;

    unique case (hit_bytes)
      SIZE_1B: rd_mask = DATA_W'(32'h0000_00FF);
      SIZE_2B: rd_mask = DATA_W'(32'h0000_FFFF);
      default: rd_mask = '1;
    endcase

    if (s0_r.func == FUNC_LOAD) begin
      load_we = SLOT_CMP_W'(s0_r.slot) < SLOT_CMP_W'(DICT_ENTRIES);
    end else if (!hit_found) begin
      rsp_nxt.emcy_valid = 1'b1;
      rsp_nxt.emcy_code  = EMCY_NO_ENTRY;
    end else if (s0_r.cmd == CMD_UPLOAD) begin
      unique case (hit_bytes)
        SIZE_1B: rsp_nxt.tx_cmd = RSP_UPLOAD_1B;
        SIZE_2B: rsp_nxt.tx_cmd = RSP_UPLOAD_2B;
        SIZE_4B: rsp_nxt.tx_cmd = RSP_UPLOAD_4B;
        default: begin
          rsp_nxt.emcy_valid = 1'b1;
          rsp_nxt.emcy_code  = EMCY_BAD_SIZE;
        end
      endcase
      if (!rsp_nxt.emcy_valid) begin
        rsp_nxt.tx_valid = 1'b1;
        rsp_nxt.tx_data  = hit_value & rd_mask;
      end
    end else begin
      unique case (s0_r.cmd)
        CMD_DNLD_1B: begin
          wr_expect = SIZE_1B;
          wr_mask   = DATA_W'(32'h0000_00FF);
        end
        CMD_DNLD_2B: begin
          wr_expect = SIZE_2B;
          wr_mask   = DATA_W'(32'h0000_FFFF);
        end
        CMD_DNLD_4B: begin
          wr_expect = SIZE_4B;
          wr_mask   = '1;
        end
        default: begin
          rsp_nxt.emcy_valid = 1'b1;
          rsp_nxt.emcy_code  = EMCY_BAD_CMD;
        end
      endcase
      if (!rsp_nxt.emcy_valid) begin
        if (wr_expect != hit_bytes) begin
          rsp_nxt.emcy_valid = 1'b1;
          rsp_nxt.emcy_code  = EMCY_SIZE_MISM;
        end else begin
          store_we         = 1'b1;
          rsp_nxt.tx_valid = 1'b1;
          rsp_nxt.tx_cmd   = RSP_DNLD_OK;
        end
      end
    end

    // Echo key and identifier on a response frame
    if (rsp_nxt.tx_valid) begin
      rsp_nxt.tx_id       = TX_ID_BASE + TX_ID_W'(node_id_r);
      rsp_nxt.tx_index    = s0_r.obj_index;
      rsp_nxt.tx_subindex = s0_r.obj_subindex;
    end
  end

  // Valid bits: clear on reset, set on load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DICT_ENTRIES; i++) begin
        entry_valid_r[i] <= 1'b0;
      end
    end else if (move && load_we) begin
      for (int i = 0; i < DICT_ENTRIES; i++) begin
        if (SLOT_CMP_W'(s0_r.slot) == SLOT_CMP_W'(i)) begin
          entry_valid_r[i] <= 1'b1;
        end
      end
    end
  end

  // Table contents: load a slot or merge written bytes into the hit slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < DICT_ENTRIES; i++) begin
      if (move && load_we && SLOT_CMP_W'(s0_r.slot) == SLOT_CMP_W'(i)) begin
        entry_index_r[i]    <= s0_r.obj_index;
        entry_subindex_r[i] <= s0_r.obj_subindex;
        entry_bytes_r[i]    <= s0_r.entry_size;
        entry_value_r[i]    <= s0_r.payload;
      end else if (move && store_we && hit_idx == DICT_IDX_W'(i)) begin
        entry_value_r[i] <= (entry_value_r[i] & ~wr_mask) | (s0_r.payload & wr_mask);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= rsp_nxt;
    end
  end

  // Drive the result channel
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.tx_valid    = out_r.tx_valid;
  assign out_rsp.tx_id       = out_r.tx_id;
  assign out_rsp.tx_cmd      = out_r.tx_cmd;
  assign out_rsp.tx_index    = out_r.tx_index;
  assign out_rsp.tx_subindex = out_r.tx_subindex;
  assign out_rsp.tx_data     = out_r.tx_data;
  assign out_rsp.emcy_valid  = out_r.emcy_valid;
  assign out_rsp.emcy_code   = out_r.emcy_code;

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.tx_valid && out_r.emcy_valid))
    else $error("response and emergency raised together");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (move && s0_r.func == FUNC_LOAD) |=>
      (out_valid_r && !out_r.tx_valid && !out_r.emcy_valid))
    else $error("load item produced a response or emergency");

  a_confirm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.tx_valid && out_r.tx_cmd == RSP_DNLD_OK) |->
      out_r.tx_data == '0)
    else $error("write confirm carries nonzero data");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_r)))
    else $error("input stage lost its item while stalled");
`endif

endmodule

>>> dv/testbench.sv
// Testbench: expedited SDO server core checked against a cycle-free dictionary predictor.
module testbench;
  import sdo_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 100;

  // Out-of-set command bytes and entry sizes used for error paths
  localparam logic [CMD_W-1:0]  CMD_BOGUS_HI = 8'hFF;
  localparam logic [CMD_W-1:0]  CMD_BOGUS_LO = 8'h00;
  localparam logic [SIZE_W-1:0] SIZE_ZERO    = 3'd0;
  localparam logic [SIZE_W-1:0] SIZE_SEVEN   = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [NODE_ID_W-1:0] cfg_wdata;

  sdo_req_if req_ch ();
  sdo_rsp_if rsp_ch ();

  sdo_expedited_server_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  // Predicted dictionary contents and node number
  logic [NODE_ID_W-1:0] node_num;
  logic                 dict_valid [DICT_ENTRIES];
  logic [INDEX_W-1:0]   dict_index [DICT_ENTRIES];
  logic [SUBIDX_W-1:0]  dict_subidx[DICT_ENTRIES];
  logic [SIZE_W-1:0]    dict_size  [DICT_ENTRIES];
  logic [DATA_W-1:0]    dict_value [DICT_ENTRIES];

  req_t req_pend_q[$];
  rsp_t rsp_due_q[$];
  req_t req_drv;
  rsp_t rsp_got;
  rsp_t rsp_want;

  int src_idle_pct;
  int snk_stall_pct;
  int err_count;
  int quiet_cycles;
  logic [INDEX_W+SUBIDX_W-1:0] key_pool[8];

  always #6 clk = ~clk;

  function automatic logic [DATA_W-1:0] size_mask(logic [SIZE_W-1:0] n);
    if (n == SIZE_1B) return 32'h0000_00FF;
    if (n == SIZE_2B) return 32'h0000_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  // Apply one transaction to the predicted dictionary and return its response
  function automatic rsp_t serve_request(req_t it);
    rsp_t                rsp;
    int                  hit;
    bit                  found;
    logic [SIZE_W-1:0]   want_size;
    logic [DATA_W-1:0]   m;
    rsp   = '0;
    hit   = 0;
    found = 1'b0;
    if (it.func == FUNC_LOAD) begin
      if (int'(it.slot) < DICT_ENTRIES) begin
        dict_valid[it.slot]  = 1'b1;
        dict_index[it.slot]  = it.obj_index;
        dict_subidx[it.slot] = it.obj_subindex;
        dict_size[it.slot]   = it.entry_size;
        dict_value[it.slot]  = it.payload;
      end
      return rsp;
    end
    // Lowest valid slot with a matching key wins
    for (int i = 0; i < DICT_ENTRIES; i++) begin
      if (!found && dict_valid[i] && dict_index[i] == it.obj_index &&
          dict_subidx[i] == it.obj_subindex) begin
        hit   = i;
        found = 1'b1;
      end
    end
    rsp.emcy_valid = 1'b1;
    if (!found) begin
      rsp.emcy_code = EMCY_NO_ENTRY;
      return rsp;
    end
    if (it.cmd == CMD_UPLOAD) begin
      case (dict_size[hit])
        SIZE_1B: rsp.tx_cmd = RSP_UPLOAD_1B;
        SIZE_2B: rsp.tx_cmd = RSP_UPLOAD_2B;
        SIZE_4B: rsp.tx_cmd = RSP_UPLOAD_4B;
        default: begin
          rsp.emcy_code = EMCY_BAD_SIZE;
          return rsp;
        end
      endcase
      rsp.tx_data = dict_value[hit] & size_mask(dict_size[hit]);
    end else begin
      case (it.cmd)
        CMD_DNLD_1B: want_size = SIZE_1B;
        CMD_DNLD_2B: want_size = SIZE_2B;
        CMD_DNLD_4B: want_size = SIZE_4B;
        default: begin
          rsp.emcy_code = EMCY_BAD_CMD;
          return rsp;
        end
      endcase
      if (want_size != dict_size[hit]) begin
        rsp.emcy_code = EMCY_SIZE_MISM;
        return rsp;
      end
      m = size_mask(want_size);
      dict_value[hit] = (dict_value[hit] & ~m) | (it.payload & m);
      rsp.tx_cmd  = RSP_DNLD_OK;
      rsp.tx_data = '0;
    end
    rsp.emcy_valid  = 1'b0;
    rsp.emcy_code   = EMCY_NO_ENTRY;
    rsp.tx_valid    = 1'b1;
    rsp.tx_id       = TX_ID_BASE + TX_ID_W'(node_num);
    rsp.tx_index    = it.obj_index;
    rsp.tx_subindex = it.obj_subindex;
    return rsp;
  endfunction

  // Random transaction: mostly loads, reads and writes on a shared key pool
  function automatic req_t random_item();
    req_t it;
    int   pick;
    it.func         = FUNC_REQUEST;
    it.cmd          = CMD_W'($urandom_range(255));
    {it.obj_index, it.obj_subindex} = key_pool[$urandom_range(7)];
    it.payload      = $urandom;
    it.slot         = SLOT_W'($urandom_range(15));
    it.entry_size   = SIZE_W'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.func = FUNC_LOAD;
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(2))
          0: it.entry_size = SIZE_1B;
          1: it.entry_size = SIZE_2B;
          default: it.entry_size = SIZE_4B;
        endcase
      end
    end else if (pick < 55) begin
      it.cmd = CMD_UPLOAD;
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0: it.cmd = CMD_DNLD_1B;
        1: it.cmd = CMD_DNLD_2B;
        default: it.cmd = CMD_DNLD_4B;
      endcase
    end else if (pick < 93) begin
      it.obj_index    = INDEX_W'($urandom);
      it.obj_subindex = SUBIDX_W'($urandom);
    end
    return it;
  endfunction

  task automatic add_item(logic f, logic [CMD_W-1:0] c, logic [INDEX_W-1:0] idx,
                          logic [SUBIDX_W-1:0] sub, logic [DATA_W-1:0] pay,
                          logic [SLOT_W-1:0] sl, logic [SIZE_W-1:0] sz);
    req_t it;
    it.func         = f;
    it.cmd          = c;
    it.obj_index    = idx;
    it.obj_subindex = sub;
    it.payload      = pay;
    it.slot         = sl;
    it.entry_size   = sz;
    req_pend_q.push_back(it);
  endtask

  // Hold until every transaction is sent and answered, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (req_pend_q.size() != 0 || req_ch.valid || rsp_due_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_node(logic [NODE_ID_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    node_num  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [NODE_ID_W-1:0] v, int src_pct, int snk_pct);
    write_node(v);
    @(negedge clk);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) req_pend_q.push_back(random_item());
    wait_idle();
  endtask

  // Driver: predict on acceptance, then hold or advance the request channel
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) rsp_due_q.push_back(serve_request(req_drv));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req_drv = req_pend_q.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.func         <= req_drv.func;
          req_ch.cmd          <= req_drv.cmd;
          req_ch.obj_index    <= req_drv.obj_index;
          req_ch.obj_subindex <= req_drv.obj_subindex;
          req_ch.payload      <= req_drv.payload;
          req_ch.slot         <= req_drv.slot;
          req_ch.entry_size   <= req_drv.entry_size;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_got = rsp_t'({rsp_ch.tx_valid, rsp_ch.tx_id, rsp_ch.tx_cmd, rsp_ch.tx_index,
                        rsp_ch.tx_subindex, rsp_ch.tx_data, rsp_ch.emcy_valid,
                        rsp_ch.emcy_code});
      if (rsp_due_q.size() == 0) begin
        if (err_count < 10)
          $display("%0t: response with nothing pending: tx=%0b id=%h cmd=%h emcy=%0b code=%0d",
                   $time, rsp_got.tx_valid, rsp_got.tx_id, rsp_got.tx_cmd,
                   rsp_got.emcy_valid, rsp_got.emcy_code);
        err_count++;
      end else begin
        rsp_want = rsp_due_q.pop_front();
        if (rsp_got !== rsp_want) begin
          if (err_count < 10) begin
            $display("%0t: mismatch exp tx=%0b id=%h cmd=%h idx=%h sub=%h data=%h emcy=%0b code=%0d",
                     $time, rsp_want.tx_valid, rsp_want.tx_id, rsp_want.tx_cmd,
                     rsp_want.tx_index, rsp_want.tx_subindex, rsp_want.tx_data,
                     rsp_want.emcy_valid, rsp_want.emcy_code);
            $display("%0t:          got tx=%0b id=%h cmd=%h idx=%h sub=%h data=%h emcy=%0b code=%0d",
                     $time, rsp_got.tx_valid, rsp_got.tx_id, rsp_got.tx_cmd,
                     rsp_got.tx_index, rsp_got.tx_subindex, rsp_got.tx_data,
                     rsp_got.emcy_valid, rsp_got.emcy_code);
          end
          err_count++;
        end
      end
    end
    rsp_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: drop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_REQUEST;
    req_ch.cmd          = '0;
    req_ch.obj_index    = '0;
    req_ch.obj_subindex = '0;
    req_ch.payload      = '0;
    req_ch.slot         = '0;
    req_ch.entry_size   = '0;
    rsp_ch.ready  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    err_count     = 0;
    quiet_cycles  = 0;
    node_num      = 7'd1;
    for (int i = 0; i < DICT_ENTRIES; i++) begin
      dict_valid[i]  = 1'b0;
      dict_index[i]  = '0;
      dict_subidx[i] = '0;
      dict_size[i]   = '0;
      dict_value[i]  = '0;
    end
    for (int k = 0; k < 8; k++) key_pool[k] = 24'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: table extremes, every command, each error path, reset node number
    @(negedge clk);
    add_item(FUNC_LOAD, CMD_BOGUS_LO, 16'h1000, 8'h00, 32'hA5A5_A5A5, 4'd0, SIZE_1B);
    add_item(FUNC_LOAD, CMD_BOGUS_HI, 16'h1000, 8'h01, 32'h1234_5678, 4'd1, SIZE_2B);
    add_item(FUNC_LOAD, CMD_UPLOAD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'd2, SIZE_4B);
    add_item(FUNC_LOAD, CMD_UPLOAD, 16'h0000, 8'h00, 32'h8000_0001, 4'd3, SIZE_ZERO);
    add_item(FUNC_LOAD, CMD_UPLOAD, 16'h2000, 8'h05, 32'h0F0F_0F0F, 4'd15, SIZE_SEVEN);
    add_item(FUNC_LOAD, CMD_UPLOAD, 16'h1000, 8'h00, 32'hDEAD_BEEF, 4'd4, SIZE_4B);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1000, 8'h00, 32'h0, 4'd15, SIZE_SEVEN);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1000, 8'h01, 32'hFFFF_FFFF, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'hFFFF, 8'hFF, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h0000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h2000, 8'h05, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1234, 8'h56, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_1B, 16'h1000, 8'h00, 32'hFFFF_FF3C, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_2B, 16'h1000, 8'h01, 32'hCAFE_00FF, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1000, 8'h01, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_4B, 16'hFFFF, 8'hFF, 32'h0000_0000, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'hFFFF, 8'hFF, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_2B, 16'h1000, 8'h00, 32'h1111_1111, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_BOGUS_HI, 16'h1000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_BOGUS_LO, 16'h1000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_4B, 16'h0000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_DNLD_4B, 16'h1234, 8'h56, 32'h0, 4'd0, SIZE_ZERO);
    add_item(FUNC_REQUEST, CMD_UPLOAD, 16'h1000, 8'h00, 32'h0, 4'd0, SIZE_ZERO);
    wait_idle();

    // Random phases across node numbers and handshake pressure
    run_phase(7'd127, 0, 0);
    run_phase(7'd0, 53, 0);
    run_phase(NODE_ID_W'($urandom_range(126, 1)), 0, 53);
    run_phase(7'd127, 19, 19);

    repeat (10) @(posedge clk);
    if (err_count == 0 && rsp_due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sdo_pkg.sv
design/sdo_if.sv
design/sdo_expedited_server_core.sv
dv/testbench.sv
